### rtl/core/smb_pkg.sv
// Shared types and constants of the subpixel mask blend.
package smb_pkg;

	localparam int CHAN_W   = 16;
	localparam int COVER_W  = 8;
	localparam int WEIGHT_W = CHAN_W + COVER_W;
	localparam int PROD_W   = CHAN_W + WEIGHT_W;
	localparam int CFG_IDX_W = 4;

	// Full-scale weight, 255 * 65535.
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 24'd16711425;
	localparam logic [CHAN_W-1:0]   CHAN_MAX    = 16'hffff;
	localparam logic [COVER_W-1:0]  COVER_MAX   = 8'hff;

	// Reciprocal of three for sums of three coverage values.
	localparam int SUM3_W     = 10;
	localparam int RECIP3_W   = 10;
	localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;
	localparam int RECIP3_SHIFT = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_OVER_RED   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVER_GREEN = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OVER_BLUE  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OVER_ALPHA = 4'd3;

	typedef struct packed {
		logic [COVER_W-1:0] mask_red;
		logic [COVER_W-1:0] mask_green;
		logic [COVER_W-1:0] mask_blue;
		logic [CHAN_W-1:0]  under_red;
		logic [CHAN_W-1:0]  under_green;
		logic [CHAN_W-1:0]  under_blue;
		logic [CHAN_W-1:0]  under_alpha;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
	} blended_t;

endpackage

### rtl/core/subpixel_mask_blend.sv
// Top level of the subpixel mask blend pipeline.
//
// Blends one RGBA destination pixel with the configured drawing colour under
// a subpixel coverage mask. A pixel is taken on every clock at which start is
// high; busy never rises, so one pixel per clock is sustained. Each result
// word appears on blended for one cycle with done high, six clocks after its
// pixel was taken, and must be captured then: the block has no way to hold
// it. The latency is set by six register stages: input capture with the
// alpha coverage, weight multiply, the two channel products, their sum, and
// two stages of division by full scale. Configuration writes are always
// ready and should be made while no pixel is in flight.
module subpixel_mask_blend (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  smb_pkg::pixel_t                   pixel,
	output smb_pkg::blended_t                 blended,
	output logic                              done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [smb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smb_pkg::CHAN_W-1:0]        cfg_data
);

	localparam int CW = smb_pkg::CHAN_W;
	localparam int MW = smb_pkg::COVER_W;
	localparam int SW = smb_pkg::SUM3_W;
	localparam int RW = SW + smb_pkg::RECIP3_W;

	logic [CW-1:0] over_red_q, over_green_q, over_blue_q, over_alpha_q;

	smb_pkg::pixel_t pix_s1;
	logic [MW-1:0]   cover_a_s1;
	logic            pass_s1;
	logic [5:1]      vld;
	logic            accept;

	logic [SW-1:0] sum3;
	logic [RW-1:0] scaled;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_comb begin
		sum3   = SW'(pixel.mask_red) + SW'(pixel.mask_green) + SW'(pixel.mask_blue);
		scaled = RW'(sum3) * RW'(smb_pkg::RECIP3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_red_q   <= '0;
			over_green_q <= '0;
			over_blue_q  <= '0;
			over_alpha_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				smb_pkg::CFG_OVER_RED:   over_red_q   <= cfg_data;
				smb_pkg::CFG_OVER_GREEN: over_green_q <= cfg_data;
				smb_pkg::CFG_OVER_BLUE:  over_blue_q  <= cfg_data;
				smb_pkg::CFG_OVER_ALPHA: over_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits follow the data down the lanes; nothing ever stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= {vld[4:1], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pixel;
			cover_a_s1 <= MW'(scaled >> smb_pkg::RECIP3_SHIFT);
			pass_s1    <= (sum3 == '0);
		end
	end

	smb_lane u_red (
		.clk(clk), .coverage(pix_s1.mask_red), .under(pix_s1.under_red), .pass(pass_s1),
		.over_c(over_red_q), .over_alpha(over_alpha_q), .result(blended.out_red)
	);

	smb_lane u_green (
		.clk(clk), .coverage(pix_s1.mask_green), .under(pix_s1.under_green), .pass(pass_s1),
		.over_c(over_green_q), .over_alpha(over_alpha_q), .result(blended.out_green)
	);

	smb_lane u_blue (
		.clk(clk), .coverage(pix_s1.mask_blue), .under(pix_s1.under_blue), .pass(pass_s1),
		.over_c(over_blue_q), .over_alpha(over_alpha_q), .result(blended.out_blue)
	);

	smb_lane u_alpha (
		.clk(clk), .coverage(cover_a_s1), .under(pix_s1.under_alpha), .pass(pass_s1),
		.over_c(over_alpha_q), .over_alpha(over_alpha_q), .result(blended.out_alpha)
	);

	// The lanes hold five further stages; done marks the last one.
	logic vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld[5];
		end
	end

	assign done = vld_s6;

endmodule

### rtl/core/smb_lane.sv
// One colour channel of the blend: weight, products, sum and division by full scale.
module smb_lane (
	input  logic                             clk,
	input  logic [smb_pkg::COVER_W-1:0]      coverage,
	input  logic [smb_pkg::CHAN_W-1:0]       under,
	input  logic                             pass,
	input  logic [smb_pkg::CHAN_W-1:0]       over_c,
	input  logic [smb_pkg::CHAN_W-1:0]       over_alpha,
	output logic [smb_pkg::CHAN_W-1:0]       result
);

	localparam int CW = smb_pkg::CHAN_W;
	localparam int WW = smb_pkg::WEIGHT_W;
	localparam int PW = smb_pkg::PROD_W;

	logic [WW-1:0] w_s2, nw_s2;
	logic [CW-1:0] under_s2, under_s3, under_s4, under_s5;
	logic          pass_s2, pass_s3, pass_s4, pass_s5;
	logic [PW-1:0] po_s3, pu_s3;
	logic [PW-1:0] sum_s4;
	logic [WW-1:0] q1_s5;
	logic [CW-1:0] res_s6;

	// First division step, by 65535: since 2^16 leaves 1 modulo 65535, the
	// digits add up to a remainder below three times the divisor.
	logic [7:0]    h;
	logic [CW-1:0] m, l;
	logic [CW+1:0] r1;
	logic [WW:0]   base1;
	logic [1:0]    corr1;
	logic [WW:0]   q1;

	// Second step, by 255, with the same trick on bytes.
	logic [7:0]    a2, a1, a0;
	logic [9:0]    r2;
	logic [CW:0]   base2;
	logic [1:0]    corr2;
	logic [CW:0]   q2;

	always_comb begin
		h  = sum_s4[PW-1:32];
		m  = sum_s4[31:16];
		l  = sum_s4[15:0];
		r1 = (CW+2)'(h) + (CW+2)'(m) + (CW+2)'(l);
		base1 = {1'b0, h, 16'b0} + (WW+1)'(h) + (WW+1)'(m);
		if (r1 >= (CW+2)'(2 * 65535)) begin
			corr1 = 2'd2;
		end else if (r1 >= (CW+2)'(65535)) begin
			corr1 = 2'd1;
		end else begin
			corr1 = 2'd0;
		end
		q1 = base1 + (WW+1)'(corr1);

		a2 = q1_s5[23:16];
		a1 = q1_s5[15:8];
		a0 = q1_s5[7:0];
		r2 = 10'(a2) + 10'(a1) + 10'(a0);
		base2 = {1'b0, a2, 8'b0} + (CW+1)'(a2) + (CW+1)'(a1);
		if (r2 >= 10'd765) begin
			corr2 = 2'd3;
		end else if (r2 >= 10'd510) begin
			corr2 = 2'd2;
		end else if (r2 >= 10'd255) begin
			corr2 = 2'd1;
		end else begin
			corr2 = 2'd0;
		end
		q2 = base2 + (CW+1)'(corr2);
	end

	always_ff @(posedge clk) begin
		w_s2     <= WW'(coverage) * WW'(over_alpha);
		nw_s2    <= smb_pkg::WEIGHT_FULL - WW'(WW'(coverage) * WW'(over_alpha));
		under_s2 <= under;
		pass_s2  <= pass;

		po_s3    <= PW'(over_c) * PW'(w_s2);
		pu_s3    <= PW'(under_s2) * PW'(nw_s2);
		under_s3 <= under_s2;
		pass_s3  <= pass_s2;

		sum_s4   <= po_s3 + pu_s3;
		under_s4 <= under_s3;
		pass_s4  <= pass_s3;

		q1_s5    <= q1[WW-1:0];
		under_s5 <= under_s4;
		pass_s5  <= pass_s4;

		res_s6   <= pass_s5 ? under_s5 : q2[CW-1:0];
	end

	assign result = res_s6;

endmodule

### rtl/core/smb_checker.sv
// Port-level checks of the subpixel mask blend, bound to the top level.
module smb_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  smb_pkg::pixel_t   pixel,
	input  smb_pkg::blended_t blended,
	input  logic              done
);

	localparam int LAT = 6;

	// The receiver cannot stall, so the block must never refuse a pixel.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result word missing after a taken pixel");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result word without a taken pixel");

	// An empty mask hands the destination pixel straight through.
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && pixel.mask_red == '0 && pixel.mask_green == '0
			&& pixel.mask_blue == '0)
		|-> ##LAT (blended.out_red == $past(pixel.under_red, LAT)
			&& blended.out_green == $past(pixel.under_green, LAT)
			&& blended.out_blue == $past(pixel.under_blue, LAT)
			&& blended.out_alpha == $past(pixel.under_alpha, LAT)))
		else $error("empty mask did not pass the pixel through");

endmodule

bind subpixel_mask_blend smb_checker u_smb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.pixel(pixel),
	.blended(blended),
	.done(done)
);
